// ===== hdl/sdm_pkg.sv =====
package sdm_pkg;

  localparam int SUM_W = 48;
  localparam int CNT_W = 20;
  localparam int VAL_W = 32;
  localparam int OP_W = 2;
  localparam int LABEL_W = 10;
  localparam int ELEM_W = 7;
  localparam int LCNT_W = 11;
  localparam int DLEN_W = 8;
  localparam int CFG_W = 11;

  localparam int MAX_LABELS_DEF = 1024;
  localparam int DESC_LEN_DEF = 128;

  localparam logic [OP_W-1:0] OP_ACC = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic CFG_LABEL_COUNT = 1'b0;
  localparam logic CFG_DESC_LENGTH = 1'b1;

  localparam logic [LCNT_W-1:0] LABEL_COUNT_RST = 11'd1024;
  localparam logic [DLEN_W-1:0] DESC_LENGTH_RST = 8'd128;

  localparam logic [CNT_W-1:0] CNT_MAX = 20'hFFFFF;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_READ  = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

endpackage

// ===== hdl/superpixel_descriptor_mean.sv =====
// accumulate: the sum memory read-modify-write
// read: states READ then EMIT when no divide is needed, READ, DIV and EMIT through the bit-serial divider
// clear: one sum entry per cycle, all MAX_LABELS*DESC_LEN sum entries per word
// throughput: one word at a time, in_stall is high until the word is finished
// reset: synchronous, runs the same clearing pass before the first word is taken
module superpixel_descriptor_mean #(
  parameter int MAX_LABELS = sdm_pkg::MAX_LABELS_DEF,
  parameter int DESC_LEN = sdm_pkg::DESC_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sdm_pkg::OP_W-1:0]           operation,
  input  logic [sdm_pkg::LABEL_W-1:0]        label,
  input  logic [sdm_pkg::ELEM_W-1:0]         element,
  input  logic signed [sdm_pkg::VAL_W-1:0]   value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sdm_pkg::VAL_W-1:0]   mean,
  output logic                               present,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [sdm_pkg::CFG_W-1:0]          cfg_data
);

  localparam int SW = sdm_pkg::SUM_W;
  localparam int CW = sdm_pkg::CNT_W;
  localparam int VW = sdm_pkg::VAL_W;
  localparam int SUM_DEPTH = MAX_LABELS * DESC_LEN;
  localparam int SAW = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int LAW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

  sdm_pkg::state_t state, state_next;

  logic [sdm_pkg::LCNT_W-1:0] label_count;
  logic [sdm_pkg::DLEN_W-1:0] desc_length;

  logic [SW-1:0] sum_mem [SUM_DEPTH];
  logic [CW-1:0] cnt_mem [MAX_LABELS];

  logic signed [SW-1:0] sum_rd;
  logic [CW-1:0]        cnt_rd;

  logic [SAW-1:0] clr_ptr;
  logic           accept;
  logic           in_lab_ok;
  logic           in_el_ok;
  logic [SAW-1:0] in_sum_addr;
  logic [LAW-1:0] in_cnt_addr;

  logic [sdm_pkg::OP_W-1:0] op_q;
  logic                     lab_ok_q;
  logic                     el_ok_q;
  logic                     el_zero_q;
  logic signed [VW-1:0]     value_q;
  logic [SAW-1:0]           sum_addr_q;
  logic [LAW-1:0]           cnt_addr_q;

  logic           sum_we;
  logic [SAW-1:0] sum_wa;
  logic [SW-1:0]  sum_wd;
  logic           cnt_we;
  logic [LAW-1:0] cnt_wa;
  logic [CW-1:0]  cnt_wd;

  logic signed [SW:0] sum_wide;
  logic [SW-1:0]      sum_sat;

  logic              rd_present;
  logic              div_start;
  logic              div_done;
  logic [SW-1:0]     div_num;
  logic [SW-1:0]     div_quo;
  logic              neg_q;
  logic [VW-1:0]     quo_sat;
  logic signed [VW-1:0] mean_q;
  logic              present_q;
  logic              emit_go;
  logic              clr_last;
  logic              clr_cnt;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != sdm_pkg::ST_IDLE);

  assign in_lab_ok = ({1'b0, label} < label_count) &&
                     ({7'b0, label} < 17'(MAX_LABELS));
  assign in_el_ok = ({1'b0, element} < desc_length) &&
                    ({4'b0, element} < 11'(DESC_LEN));
  assign in_sum_addr = SAW'(SAW'(label) * SAW'(DESC_LEN) + SAW'(element));
  assign in_cnt_addr = LAW'(label);

  assign clr_last = (clr_ptr == SAW'(SUM_DEPTH - 1));
  assign clr_cnt = ({1'b0, clr_ptr} < (SAW+1)'(MAX_LABELS));

  // saturating accumulate
  always_comb begin
    sum_wide = {sum_rd[SW-1], sum_rd} + (SW+1)'(value_q);
    if (sum_wide[SW] != sum_wide[SW-1]) begin
      sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end
  end

  assign rd_present = lab_ok_q && (cnt_rd != '0);
  assign div_start = (state == sdm_pkg::ST_READ) && rd_present && el_ok_q;
  assign div_num = sum_rd[SW-1] ? SW'(-sum_rd) : sum_rd;
  assign emit_go = !out_valid || !out_stall;

  always_comb begin
    if (!neg_q) begin
      quo_sat = (div_quo > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[VW-1:0];
    end else begin
      quo_sat = (div_quo > 48'h0000_8000_0000) ? 32'h8000_0000 :
                (~div_quo[VW-1:0]) + 32'd1;
    end
  end

  // memory write port control
  always_comb begin
    sum_we = 1'b0;
    sum_wa = sum_addr_q;
    sum_wd = sum_sat;
    cnt_we = 1'b0;
    cnt_wa = cnt_addr_q;
    cnt_wd = cnt_rd + 1'b1;
    case (state)
      sdm_pkg::ST_CLEAR: begin
        sum_we = 1'b1;
        sum_wa = clr_ptr;
        sum_wd = '0;
        cnt_we = clr_cnt;
        cnt_wa = LAW'(clr_ptr);
        cnt_wd = '0;
      end
      sdm_pkg::ST_ACC: begin
        sum_we = 1'b1;
        cnt_we = el_zero_q && (cnt_rd != sdm_pkg::CNT_MAX);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      sdm_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = sdm_pkg::ST_IDLE;
        end
      end
      sdm_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation == sdm_pkg::OP_ACC && in_lab_ok && in_el_ok) begin
            state_next = sdm_pkg::ST_ACC;
          end else if (operation == sdm_pkg::OP_READ) begin
            state_next = sdm_pkg::ST_READ;
          end else if (operation == sdm_pkg::OP_CLEAR) begin
            state_next = sdm_pkg::ST_CLEAR;
          end
        end
      end
      sdm_pkg::ST_ACC: begin
        state_next = sdm_pkg::ST_IDLE;
      end
      sdm_pkg::ST_READ: begin
        state_next = div_start ? sdm_pkg::ST_DIV : sdm_pkg::ST_EMIT;
      end
      sdm_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = sdm_pkg::ST_EMIT;
        end
      end
      sdm_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_next = sdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sdm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdm_pkg::ST_CLEAR;
      clr_ptr <= '0;
      out_valid <= 1'b0;
      label_count <= sdm_pkg::LABEL_COUNT_RST;
      desc_length <= sdm_pkg::DESC_LENGTH_RST;
    end else begin
      state <= state_next;
      if (state == sdm_pkg::ST_CLEAR) begin
        clr_ptr <= clr_last ? '0 : clr_ptr + 1'b1;
      end
      if (state == sdm_pkg::ST_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          sdm_pkg::CFG_LABEL_COUNT: label_count <= cfg_data;
          sdm_pkg::CFG_DESC_LENGTH: desc_length <= cfg_data[sdm_pkg::DLEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // word capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= operation;
      lab_ok_q <= in_lab_ok;
      el_ok_q <= in_el_ok;
      el_zero_q <= (element == '0);
      value_q <= value;
      sum_addr_q <= in_sum_addr;
      cnt_addr_q <= in_cnt_addr;
    end
    if (state == sdm_pkg::ST_READ) begin
      neg_q <= sum_rd[SW-1];
      mean_q <= '0;
      present_q <= rd_present;
    end
    if (state == sdm_pkg::ST_DIV && div_done && op_q == sdm_pkg::OP_READ) begin
      mean_q <= quo_sat;
    end
    if (state == sdm_pkg::ST_EMIT && emit_go) begin
      mean <= mean_q;
      present <= present_q;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_rd <= sum_mem[in_sum_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd <= cnt_mem[in_cnt_addr];
  end

  sdm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cnt_rd),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule

// ===== hdl/sdm_div.sv =====
module sdm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sdm_pkg::SUM_W-1:0]   num,
  input  logic [sdm_pkg::CNT_W-1:0]   den,
  output logic                        done,
  output logic [sdm_pkg::SUM_W-1:0]   quo
);

  localparam int SW = sdm_pkg::SUM_W;
  localparam int CW = sdm_pkg::CNT_W;
  localparam int IW = $clog2(SW);
  localparam logic [IW-1:0] LAST = IW'(SW - 1);

  logic          busy;
  logic [IW-1:0] iter;
  logic [CW-1:0] rem;
  logic [CW-1:0] rem_next;
  logic [CW-1:0] den_q;
  logic [CW:0]   rem_shift;
  logic          qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_shift = {rem, quo[SW-1]};
    qbit = rem_shift >= {1'b0, den_q};
    if (qbit) begin
      rem_next = CW'(rem_shift - {1'b0, den_q});
    end else begin
      rem_next = rem_shift[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + 1'b1;
        if (iter == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[SW-2:0], qbit};
      rem <= rem_next;
    end
  end

endmodule
